FILE: sv/sdr_pkg.sv
package sdr_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // latch a new element and restart the table scan
      logic step;    // read the next stored entry and advance the scan index
      logic finish;  // decide, append if new and the table has room, and present the result
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;    // stored entries remain to be read
      logic pend;    // a read is in flight and its compare is still to come
   } ctrl_status_type;

   localparam int unsigned COUNT_FIELD_W = 6;

endpackage

FILE: sv/stream_duplicate_remover_unit.sv
// Duplicate remover: each accepted byte is checked against the distinct values already stored
// for the current set by reading the table one entry per cycle. Busy stays high while the
// stored values are read, then for the last compare and for the decision, or only for the
// decision when the table is empty, and the result strobes in the cycle after busy falls. At
// the default depth of 32 the table holds up to 32 values. The single read port of the table
// memory makes the busy time grow with the number of stored values. A new element may be
// started in the same cycle as the previous result's strobe. Results are presented for one
// cycle only and the receiver cannot stall them. After reset the block is ready at once; no
// clearing pass is needed.
module stream_duplicate_remover_unit #(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_value,
   input  logic       req_starts_set,
   input  logic       req_ends_set,
   output logic       rsp_strobe,
   output logic [7:0] rsp_value_out,
   output logic       rsp_kept,
   output logic [5:0] rsp_unique_count,
   output logic       rsp_dropped_full,
   output logic       rsp_last_out
);

   sdr_pkg::ctrl_cmd_type    cmd;
   sdr_pkg::ctrl_status_type status;

   sdr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   sdr_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .req_starts_set   (req_starts_set),
      .req_ends_set     (req_ends_set),
      .rsp_strobe       (rsp_strobe),
      .rsp_value_out    (rsp_value_out),
      .rsp_kept         (rsp_kept),
      .rsp_unique_count (rsp_unique_count),
      .rsp_dropped_full (rsp_dropped_full),
      .rsp_last_out     (rsp_last_out)
   );

   // A result always closes a busy period and leaves the block ready.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(busy) && !busy)
      else $error("result strobe without a preceding scan");

   // A value is either stored or dropped, never both.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_strobe |-> !(rsp_kept && rsp_dropped_full))
      else $error("kept and dropped_full both set");

   // A transfer always starts a scan.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted element did not start a scan");

   // The controller only finishes once no read is in flight.
   assert property (@(posedge clock) disable iff (reset)
                    cmd.finish |-> !status.pend && !status.more)
      else $error("finish issued during a table scan");

endmodule

FILE: sv/sdr_ctrl.sv
module sdr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  sdr_pkg::ctrl_status_type status,
   output sdr_pkg::ctrl_cmd_type    cmd,
   output logic                     busy
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.more) begin
               cmd.step = 1'b1;
            end else if (!status.pend) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_SCAN);

endmodule

FILE: sv/sdr_datapath.sv
module sdr_datapath #(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sdr_pkg::ctrl_cmd_type    cmd,
   output sdr_pkg::ctrl_status_type status,
   input  logic [7:0]               req_value,
   input  logic                     req_starts_set,
   input  logic                     req_ends_set,
   output logic                     rsp_strobe,
   output logic [7:0]               rsp_value_out,
   output logic                     rsp_kept,
   output logic [5:0]               rsp_unique_count,
   output logic                     rsp_dropped_full,
   output logic                     rsp_last_out
);

   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned XW = (CW > sdr_pkg::COUNT_FIELD_W) ? CW : sdr_pkg::COUNT_FIELD_W;

   logic [7:0]    seen_mem [TABLE_DEPTH];

   logic [7:0]    value_ff;
   logic          last_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff;
   logic          hit_ff, hit_in;
   logic [7:0]    rd_data_ff;

   logic          is_new;
   logic          store;
   logic [CW-1:0] count_next;
   logic [XW-1:0] count_ext;

   logic          strobe_ff;
   logic [7:0]    out_value_ff;
   logic          out_kept_ff;
   logic [5:0]    out_count_ff;
   logic          out_dropped_ff;
   logic          out_last_ff;

   assign is_new     = !hit_ff;
   assign store      = is_new && (count_ff < CW'(TABLE_DEPTH));
   assign count_next = store ? count_ff + CW'(1) : count_ff;
   assign count_ext  = XW'(count_next);

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      if (cmd.load) begin
         if (req_starts_set) begin
            count_in = '0;
         end
         idx_in = '0;
         hit_in = 1'b0;
      end else begin
         if (cmd.step) begin
            idx_in = idx_ff + CW'(1);
         end
         if (pend_ff && (rd_data_ff == value_ff)) begin
            hit_in = 1'b1;
         end
         if (cmd.finish) begin
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
         hit_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         pend_ff   <= cmd.step;
         hit_ff    <= hit_in;
         strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
         last_ff  <= req_ends_set;
      end
      if (cmd.finish) begin
         out_value_ff   <= value_ff;
         out_kept_ff    <= store;
         out_count_ff   <= count_ext[5:0];
         out_dropped_ff <= is_new && !store;
         out_last_ff    <= last_ff;
      end
   end

   // Entries are only ever read below the fill count, so the table needs no clearing.
   always_ff @(posedge clock) begin
      if (cmd.finish && store) begin
         seen_mem[count_ff[AW-1:0]] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rd_data_ff <= seen_mem[idx_ff[AW-1:0]];
      end
   end

   assign status.more = (idx_ff < count_ff);
   assign status.pend = pend_ff;

   assign rsp_strobe       = strobe_ff;
   assign rsp_value_out    = out_value_ff;
   assign rsp_kept         = out_kept_ff;
   assign rsp_unique_count = out_count_ff;
   assign rsp_dropped_full = out_dropped_ff;
   assign rsp_last_out     = out_last_ff;

endmodule
